// ===== hw/rtl/gem_pkg.sv =====
// ----------------------------------------------------------------------------
// gem_pkg
// Shared constants, types and state encodings of the edge magnitude stream.
// ----------------------------------------------------------------------------
package gem_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int SizeW     = 12;
    localparam int PixW      = 8;
    localparam int GradW     = 12;
    localparam int SumW      = 23;
    localparam int RootSteps = 8;

    localparam logic [16:0] GrayCoefR = 17'd19595;
    localparam logic [16:0] GrayCoefG = 17'd38470;
    localparam logic [16:0] GrayCoefB = 17'd7471;

    localparam logic [SizeW-1:0] SizeMin   = SizeW'(3);
    localparam logic [SizeW-1:0] WidthMax  = SizeW'(MaxWidth);
    localparam logic [SizeW-1:0] HeightMax = SizeW'(MaxHeight);

    localparam logic [1:0] OpSobel   = 2'd0;
    localparam logic [1:0] OpPrewitt = 2'd1;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegMode   = 2'd2;

    typedef enum logic [1:0] {F_IDLE, F_UPD, F_PUSH} t_fstate;
    typedef enum logic [2:0] {B_IDLE, B_GRAD, B_SQR, B_ROOT, B_EMIT} t_bstate;

    typedef struct packed {
        logic [SizeW-1:0] w_last;
        logic [SizeW-1:0] h_last;
        logic [1:0]       mode;
    } t_cfg;

    // one transaction's worth of work for the back end
    typedef struct packed {
        logic [8:0][PixW-1:0] win;
        logic [PixW-1:0]      gray;
        logic [RowW-1:0]      row;
        logic [ColW-1:0]      col;
        logic [3:0]           emit;
        logic                 border0;
        logic [1:0]           mode;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hw/rtl/gem_front.sv =====
// ----------------------------------------------------------------------------
// gem_front
// Gray conversion, line stores, 3x3 window and result classification.
// ----------------------------------------------------------------------------
module gem_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [gem_pkg::PixW-1:0]         i_red,
    input  logic [gem_pkg::PixW-1:0]         i_green,
    input  logic [gem_pkg::PixW-1:0]         i_blue,
    input  gem_pkg::t_cfg                    i_cfg,
    output logic                             o_push,
    output gem_pkg::t_job                    o_job,
    input  gem_pkg::t_qstat                  i_qstat
);

    gem_pkg::t_fstate r_state, n_state;

    logic [gem_pkg::PixW-1:0] mem_a [gem_pkg::MaxWidth];
    logic [gem_pkg::PixW-1:0] mem_b [gem_pkg::MaxWidth];

    logic [gem_pkg::PixW-1:0] r_top, r_mid, r_gray;
    logic [8:0][gem_pkg::PixW-1:0] r_win;
    logic [gem_pkg::RowW-1:0] r_row_cnt, r_cur_row;
    logic [gem_pkg::ColW-1:0] r_col_cnt, r_cur_col;

    logic        accept;
    logic [24:0] gray_sum;
    logic        last_col, last_row;
    logic [3:0]  emit;

    assign accept = (r_state == gem_pkg::F_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != gem_pkg::F_IDLE);

    assign gray_sum = 25'(gem_pkg::GrayCoefR) * 25'(i_red)
                    + 25'(gem_pkg::GrayCoefG) * 25'(i_green)
                    + 25'(gem_pkg::GrayCoefB) * 25'(i_blue);

    assign last_col = {1'b0, r_cur_col} >= i_cfg.w_last;
    assign last_row = {1'b0, r_cur_row} >= i_cfg.h_last;

    always_comb begin
        emit[0] = (r_cur_row != '0) && (r_cur_col != '0);
        emit[1] = last_col && (r_cur_row != '0);
        emit[2] = last_row && (r_cur_col != '0);
        emit[3] = last_row && last_col;
    end

    always_comb begin
        o_job.win     = r_win;
        o_job.gray    = r_gray;
        o_job.row     = r_cur_row;
        o_job.col     = r_cur_col;
        o_job.emit    = emit;
        o_job.mode    = i_cfg.mode;
        o_job.border0 = (i_cfg.mode == gem_pkg::OpSobel || i_cfg.mode == gem_pkg::OpPrewitt)
                        && (r_cur_row == gem_pkg::RowW'(1) || r_cur_col == gem_pkg::ColW'(1));
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            gem_pkg::F_IDLE: begin
                if (accept) n_state = gem_pkg::F_UPD;
            end
            gem_pkg::F_UPD: n_state = gem_pkg::F_PUSH;
            gem_pkg::F_PUSH: begin
                if (emit == 4'b0) begin
                    n_state = gem_pkg::F_IDLE;
                end else if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = gem_pkg::F_IDLE;
                end
            end
            default: n_state = gem_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gem_pkg::F_IDLE;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_win     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gem_pkg::F_UPD) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_top;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= r_mid;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_gray;
                if (last_col) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= last_row ? '0 : r_cur_row + 1'b1;
                end else begin
                    r_col_cnt <= r_cur_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gray    <= gray_sum[23:16];
            r_cur_row <= r_row_cnt;
            r_cur_col <= r_col_cnt;
        end
    end

    // line stores: read on accept, written back in the following F_UPD cycle
    always_ff @(posedge i_clk) begin
        if (accept) r_top <= mem_b[r_col_cnt];
        if (r_state == gem_pkg::F_UPD) mem_b[r_cur_col] <= r_mid;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_mid <= mem_a[r_col_cnt];
        if (r_state == gem_pkg::F_UPD) mem_a[r_cur_col] <= r_gray;
    end

endmodule

// ===== hw/rtl/gem_queue.sv =====
// ----------------------------------------------------------------------------
// gem_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module gem_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gem_pkg::t_job   i_job,
    input  logic            i_pop,
    output gem_pkg::t_job   o_job,
    output gem_pkg::t_qstat o_qstat
);

    gem_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job         = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ===== hw/rtl/gem_back.sv =====
// ----------------------------------------------------------------------------
// gem_back
// Gradient, magnitude (iterative square root) and result sequencing.
// ----------------------------------------------------------------------------
module gem_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gem_pkg::t_job                 i_job,
    input  gem_pkg::t_qstat               i_qstat,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gem_pkg::PixW-1:0]      o_pixel_value,
    output logic [gem_pkg::RowW-1:0]      o_out_row,
    output logic [gem_pkg::ColW-1:0]      o_out_col,
    output logic                          o_is_border,
    output logic                          o_last_of_run
);

    gem_pkg::t_bstate r_state, n_state;
    gem_pkg::t_job    r_job;

    logic signed [gem_pkg::GradW-1:0] r_gx, r_gy, gx, gy;
    logic [gem_pkg::SumW-1:0] r_sum;
    logic [15:0] r_v, r_bit;
    logic [16:0] r_res, trial;
    logic [2:0]  r_step;
    logic [3:0]  r_pend, sel;
    logic [gem_pkg::PixW-1:0] mag;
    logic        slot_free;
    logic signed [2*gem_pkg::GradW-1:0] sqx, sqy;

    localparam logic [2:0] LastStep = 3'(gem_pkg::RootSteps - 1);

    function automatic logic signed [gem_pkg::GradW-1:0] px(input logic [gem_pkg::PixW-1:0] v);
        px = gem_pkg::GradW'($signed({1'b0, v}));
    endfunction

    always_comb begin
        logic [8:0][gem_pkg::PixW-1:0] w;
        w = r_job.win;
        case (r_job.mode)
            gem_pkg::OpSobel: begin
                gx = (px(w[2]) + (px(w[5]) <<< 1) + px(w[8]))
                   - (px(w[0]) + (px(w[3]) <<< 1) + px(w[6]));
                gy = (px(w[0]) + (px(w[1]) <<< 1) + px(w[2]))
                   - (px(w[6]) + (px(w[7]) <<< 1) + px(w[8]));
            end
            gem_pkg::OpPrewitt: begin
                gx = (px(w[2]) + px(w[5]) + px(w[8])) - (px(w[0]) + px(w[3]) + px(w[6]));
                gy = (px(w[0]) + px(w[1]) + px(w[2])) - (px(w[6]) + px(w[7]) + px(w[8]));
            end
            default: begin
                gx = px(w[4]) - px(w[8]);
                gy = px(w[5]) - px(w[7]);
            end
        endcase
    end

    assign sqx   = r_gx * r_gx;
    assign sqy   = r_gy * r_gy;
    assign trial = r_res + {1'b0, r_bit};

    assign slot_free = !o_out_valid || !i_out_stall;

    always_comb begin
        sel = 4'b0;
        if (r_pend[0])      sel = 4'b0001;
        else if (r_pend[1]) sel = 4'b0010;
        else if (r_pend[2]) sel = 4'b0100;
        else if (r_pend[3]) sel = 4'b1000;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            gem_pkg::B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_state = (i_job.emit[0] && !i_job.border0) ? gem_pkg::B_GRAD
                                                                 : gem_pkg::B_EMIT;
                end
            end
            gem_pkg::B_GRAD: n_state = gem_pkg::B_SQR;
            gem_pkg::B_SQR:  n_state = gem_pkg::B_ROOT;
            gem_pkg::B_ROOT: begin
                if (r_step == LastStep) n_state = gem_pkg::B_EMIT;
            end
            gem_pkg::B_EMIT: begin
                if (slot_free && (r_pend & ~sel) == 4'b0) n_state = gem_pkg::B_IDLE;
            end
            default: n_state = gem_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gem_pkg::B_IDLE;
            r_pend      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) r_pend <= i_job.emit;
            if (r_state == gem_pkg::B_EMIT && slot_free) begin
                r_pend      <= r_pend & ~sel;
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_state == gem_pkg::B_GRAD) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (r_state == gem_pkg::B_SQR) begin
            r_sum  <= gem_pkg::SumW'(sqx) + gem_pkg::SumW'(sqy);
            r_v    <= 16'(gem_pkg::SumW'(sqx) + gem_pkg::SumW'(sqy));
            r_res  <= '0;
            r_bit  <= 16'h4000;
            r_step <= '0;
        end
        if (r_state == gem_pkg::B_ROOT) begin
            if ({1'b0, r_v} >= trial) begin
                r_v   <= 16'({1'b0, r_v} - trial);
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step + 1'b1;
        end
        if (r_state == gem_pkg::B_EMIT && slot_free) begin
            o_last_of_run <= (r_pend & ~sel) == 4'b0;
            case (sel)
                4'b0001: begin
                    o_pixel_value <= r_job.border0 ? r_job.win[4] : mag;
                    o_out_row     <= r_job.row - 1'b1;
                    o_out_col     <= r_job.col - 1'b1;
                    o_is_border   <= r_job.border0;
                end
                4'b0010: begin
                    o_pixel_value <= r_job.win[5];
                    o_out_row     <= r_job.row - 1'b1;
                    o_out_col     <= r_job.col;
                    o_is_border   <= 1'b1;
                end
                4'b0100: begin
                    o_pixel_value <= r_job.win[7];
                    o_out_row     <= r_job.row;
                    o_out_col     <= r_job.col - 1'b1;
                    o_is_border   <= 1'b1;
                end
                default: begin
                    o_pixel_value <= r_job.gray;
                    o_out_row     <= r_job.row;
                    o_out_col     <= r_job.col;
                    o_is_border   <= 1'b1;
                end
            endcase
        end
    end

    // magnitude saturates once the squared sum reaches 2^16
    assign mag = (r_sum >= gem_pkg::SumW'(65536)) ? 8'hFF : r_res[7:0];

endmodule

// ===== hw/rtl/gradient_edge_magnitude_stream.sv =====
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_stream
// RGB raster stream to gray, then Sobel / Prewitt / Roberts edge magnitude.
// ----------------------------------------------------------------------------
// Flow: the front end takes one pixel transaction at a time through F_IDLE (line
//   store read), F_UPD (window update) and F_PUSH (queue push, held while the queue
//   is full); the back end pops a job, runs an interior pixel through gradient,
//   squares and an 8-step square root (a border-only job skips these), then emits
//   each result, held while the output is stalled.
// Reset: synchronous active low; clears control, window, counters (not line stores).
module gradient_edge_magnitude_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gem_pkg::PixW-1:0]      i_red,
    input  logic [gem_pkg::PixW-1:0]      i_green,
    input  logic [gem_pkg::PixW-1:0]      i_blue,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gem_pkg::PixW-1:0]      o_pixel_value,
    output logic [gem_pkg::RowW-1:0]      o_out_row,
    output logic [gem_pkg::ColW-1:0]      o_out_col,
    output logic                          o_is_border,
    output logic                          o_last_of_run,
    // APB-style register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [gem_pkg::SizeW-1:0] r_frame_width, r_frame_height;
    logic [1:0]                r_operator_mode;
    logic [gem_pkg::SizeW-1:0] width_eff, height_eff;
    logic                      wr_en;

    gem_pkg::t_cfg   cfg;
    gem_pkg::t_job   push_job, pop_job;
    gem_pkg::t_qstat qstat;
    logic            q_push, q_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= gem_pkg::SizeW'(640);
            r_frame_height  <= gem_pkg::SizeW'(480);
            r_operator_mode <= gem_pkg::OpSobel;
        end else if (wr_en) begin
            case (paddr[3:2])
                gem_pkg::RegWidth:  r_frame_width   <= pwdata[gem_pkg::SizeW-1:0];
                gem_pkg::RegHeight: r_frame_height  <= pwdata[gem_pkg::SizeW-1:0];
                gem_pkg::RegMode:   r_operator_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gem_pkg::RegWidth:  prdata = 32'(r_frame_width);
            gem_pkg::RegHeight: prdata = 32'(r_frame_height);
            gem_pkg::RegMode:   prdata = 32'(r_operator_mode);
            default:            prdata = '0;
        endcase
    end

    // out-of-range sizes are pinned into [3, max]
    always_comb begin
        if (r_frame_width < gem_pkg::SizeMin)       width_eff = gem_pkg::SizeMin;
        else if (r_frame_width > gem_pkg::WidthMax) width_eff = gem_pkg::WidthMax;
        else                                        width_eff = r_frame_width;
        if (r_frame_height < gem_pkg::SizeMin)        height_eff = gem_pkg::SizeMin;
        else if (r_frame_height > gem_pkg::HeightMax) height_eff = gem_pkg::HeightMax;
        else                                          height_eff = r_frame_height;
        cfg.w_last = width_eff - 1'b1;
        cfg.h_last = height_eff - 1'b1;
        cfg.mode   = r_operator_mode;
    end

    gem_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_cfg      (cfg),
        .o_push     (q_push),
        .o_job      (push_job),
        .i_qstat    (qstat)
    );

    gem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_qstat (qstat)
    );

    gem_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (pop_job),
        .i_qstat       (qstat),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_value (o_pixel_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_is_border   (o_is_border),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTH
    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !qstat.full) else $error("job queue overflow");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !qstat.empty) else $error("job queue underflow");

    // an accepted pixel keeps the front busy in the next cycle
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("front took two pixels");
`endif

endmodule
